// ===== rtl/wmad_pkg.sv =====
// ----------------------------------------------------------------------------
// wmad_pkg: shared types and constants for the window mean-abs-deviation core
// Holds the config register layout and the datapath control word.
// ----------------------------------------------------------------------------
package wmad_pkg;

  localparam int CFG_W = 7;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd32;

  typedef enum logic [1:0] {
    ALU_HOLD,
    ALU_LOAD_CENTER,
    ALU_ACCUM,
    ALU_DIV_STEP
  } alu_op_t;

  typedef struct packed {
    alu_op_t op;
    logic    clear;
  } alu_ctrl_t;

endpackage

// ===== rtl/wmad_ring_ram.sv =====
// ----------------------------------------------------------------------------
// wmad_ring_ram: sample window storage
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module wmad_ring_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/wmad_alu.sv =====
// ----------------------------------------------------------------------------
// wmad_alu: shared arithmetic unit
// Accumulates |center - sample|, then divides the sum by K one bit a cycle
// (restoring division, quotient shifts into the accumulator).
// ----------------------------------------------------------------------------
module wmad_alu #(
  parameter int SAMPLE_BITS = 16,
  parameter int KW          = 7,
  parameter int SUMW        = 22
) (
  input  logic                   clk,
  input  wmad_pkg::alu_ctrl_t    ctrl,
  input  logic [KW-1:0]          k,
  input  logic [SAMPLE_BITS-1:0] rd_data,
  output logic [SAMPLE_BITS-1:0] result
);

  logic signed [SAMPLE_BITS-1:0] center_r, center_nxt;
  logic [SUMW-1:0]               acc_r, acc_nxt;
  logic [KW-1:0]                 rem_r, rem_nxt;

  logic signed [SAMPLE_BITS:0]   diff;
  logic [SAMPLE_BITS:0]          abs_diff;
  logic [KW:0]                   shifted;
  logic [KW:0]                   trial;
  logic                          ge;

  assign diff     = {center_r[SAMPLE_BITS-1], center_r} -
                    {rd_data[SAMPLE_BITS-1], rd_data};
  assign abs_diff = diff[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-diff) : diff;
  assign shifted  = {rem_r, acc_r[SUMW-1]};
  assign ge       = shifted >= {1'b0, k};
  assign trial    = shifted - {1'b0, k};

  always_comb begin
    center_nxt = center_r;
    acc_nxt    = acc_r;
    rem_nxt    = rem_r;
    unique case (ctrl.op)
      wmad_pkg::ALU_HOLD: begin
      end
      wmad_pkg::ALU_LOAD_CENTER: begin
        center_nxt = rd_data;
      end
      wmad_pkg::ALU_ACCUM: begin
        acc_nxt = acc_r + SUMW'(abs_diff);
      end
      wmad_pkg::ALU_DIV_STEP: begin
        rem_nxt = ge ? trial[KW-1:0] : shifted[KW-1:0];
        acc_nxt = {acc_r[SUMW-2:0], ge};
      end
      default: begin
      end
    endcase
    if (ctrl.clear) begin
      acc_nxt = '0;
      rem_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    center_r <= center_nxt;
    acc_r    <= acc_nxt;
    rem_r    <= rem_nxt;
  end

  assign result = acc_r[SAMPLE_BITS-1:0];

endmodule

// ===== rtl/window_mean_abs_deviation_core.sv =====
// Per result: a center read, K window reads through the single RAM read port,
//   then one quotient bit per cycle in the shared ALU for SUMW = SAMPLE_BITS
//   + clog2(MAX_WINDOW) bits. Input is taken only in S_IDLE, so the next sample
//   waits until the result is registered; samples that give no result do not.
// Reset: rst_n synchronous, clears pointers, fill count, window_size (to 32)
//   and the output valid. Window RAM is not cleared.
// ----------------------------------------------------------------------------
// window_mean_abs_deviation_core: sliding-window mean absolute deviation
// Ring of recent samples; once K samples are held, each new sample sums
// |center - x| over the newest K and divides the sum by K.
// ----------------------------------------------------------------------------
module window_mean_abs_deviation_core #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_wr_en,
  input  logic [wmad_pkg::CFG_W-1:0]              cfg_wr_data,   // window_size
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]        in_tdata,      // sample
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]        out_tdata      // noise_level
);

  localparam int AW   = $clog2(MAX_WINDOW);
  localparam int KW   = $clog2(MAX_WINDOW + 1);
  localparam int SUMW = SAMPLE_BITS + AW;
  localparam int DCW  = $clog2(SUMW);
  localparam int DW   = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int CMPW = (KW > wmad_pkg::CFG_W) ? KW : wmad_pkg::CFG_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_CENTER,
    S_ACCUM,
    S_DIV,
    S_DONE
  } state_t;

  state_t                     state_r, state_nxt;
  logic [wmad_pkg::CFG_W-1:0] cfg_r;
  logic [AW-1:0]              wp_r, wp_nxt;
  logic [KW-1:0]              fill_r, fill_nxt;
  logic [KW-1:0]              k_r, k_nxt;
  logic [AW-1:0]              ptr_r, ptr_nxt;
  logic [KW-1:0]              cnt_r, cnt_nxt;
  logic [DCW-1:0]             div_cnt_r, div_cnt_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0]     out_data_r, out_data_nxt;

  logic [KW-1:0]              k_eff;
  logic [CMPW-1:0]            cfg_ext;
  logic [KW-1:0]              fill_inc;
  logic [AW-1:0]              wp_inc;
  logic [AW-1:0]              ptr_inc;
  logic [KW:0]                wpx, kx, mx, oldest_x, center_x, center_sum;
  logic                       in_xfer;

  logic                       wr_en;
  logic                       rd_en;
  logic [AW-1:0]              rd_addr;
  logic [SAMPLE_BITS-1:0]     rd_data;
  logic [SAMPLE_BITS-1:0]     alu_result;
  wmad_pkg::alu_ctrl_t        alu_ctrl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= wmad_pkg::CFG_RESET;
    end else if (cfg_wr_en) begin
      cfg_r <= cfg_wr_data;
    end
  end

  assign cfg_ext = CMPW'(cfg_r);

  always_comb begin
    if (cfg_r == '0) begin
      k_eff = KW'(1);
    end else if (cfg_ext > CMPW'(MAX_WINDOW)) begin
      k_eff = KW'(MAX_WINDOW);
    end else begin
      k_eff = cfg_ext[KW-1:0];
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign fill_inc  = (fill_r == KW'(MAX_WINDOW)) ? fill_r : fill_r + KW'(1);
  assign wp_inc    = (wp_r == AW'(MAX_WINDOW - 1)) ? '0 : wp_r + AW'(1);
  assign ptr_inc   = (ptr_r == AW'(MAX_WINDOW - 1)) ? '0 : ptr_r + AW'(1);

  // oldest = wp - K, center = oldest + K/2, both mod MAX_WINDOW
  assign wpx        = (KW+1)'(wp_r);
  assign kx         = (KW+1)'(k_r);
  assign mx         = (KW+1)'(MAX_WINDOW);
  assign oldest_x   = (wpx >= kx) ? wpx - kx : wpx + mx - kx;
  assign center_sum = oldest_x + (kx >> 1);
  assign center_x   = (center_sum >= mx) ? center_sum - mx : center_sum;

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    fill_nxt      = fill_r;
    k_nxt         = k_r;
    ptr_nxt       = ptr_r;
    cnt_nxt       = cnt_r;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = ptr_r;
    alu_ctrl      = '{op: wmad_pkg::ALU_HOLD, clear: 1'b0};

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          wr_en    = 1'b1;
          wp_nxt   = wp_inc;
          fill_nxt = fill_inc;
          k_nxt    = k_eff;
          if (fill_inc >= k_eff) begin
            state_nxt = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        rd_en     = 1'b1;
        rd_addr   = center_x[AW-1:0];
        ptr_nxt   = oldest_x[AW-1:0];
        cnt_nxt   = '0;
        state_nxt = S_CENTER;
      end
      S_CENTER: begin
        alu_ctrl  = '{op: wmad_pkg::ALU_LOAD_CENTER, clear: 1'b1};
        rd_en     = 1'b1;
        ptr_nxt   = ptr_inc;
        cnt_nxt   = cnt_r + KW'(1);
        state_nxt = S_ACCUM;
      end
      S_ACCUM: begin
        // the center's own term is zero, no skip needed
        alu_ctrl = '{op: wmad_pkg::ALU_ACCUM, clear: 1'b0};
        if (cnt_r == k_r) begin
          div_cnt_nxt = '0;
          state_nxt   = S_DIV;
        end else begin
          rd_en   = 1'b1;
          ptr_nxt = ptr_inc;
          cnt_nxt = cnt_r + KW'(1);
        end
      end
      S_DIV: begin
        alu_ctrl    = '{op: wmad_pkg::ALU_DIV_STEP, clear: 1'b0};
        div_cnt_nxt = div_cnt_r + DCW'(1);
        if (div_cnt_r == DCW'(SUMW - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = alu_result;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      fill_r      <= '0;
      k_r         <= '0;
      ptr_r       <= '0;
      cnt_r       <= '0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      k_r         <= k_nxt;
      ptr_r       <= ptr_nxt;
      cnt_r       <= cnt_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  wmad_ring_ram #(
    .DEPTH (MAX_WINDOW),
    .WIDTH (SAMPLE_BITS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wp_r),
    .wr_data (in_tdata[SAMPLE_BITS-1:0]),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  wmad_alu #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .KW          (KW),
    .SUMW        (SUMW)
  ) u_alu (
    .clk     (clk),
    .ctrl    (alu_ctrl),
    .k       (k_r),
    .rd_data (rd_data),
    .result  (alu_result)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = DW'(out_data_r);

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= KW'(MAX_WINDOW))
    else $error("fill count beyond window depth");

  a_short_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (fill_inc < k_eff)) |=> in_tready)
    else $error("item without result stalled input");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_DONE))
    else $error("result raised outside completion");

  a_read_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACCUM) |-> (cnt_r <= k_r) && (cnt_r != '0))
    else $error("window read count out of range");

  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SETUP) |-> (k_r != '0) && (k_r <= fill_r))
    else $error("window size invalid at setup");

endmodule

// ===== tb/tb_window_mean_abs_deviation_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_window_mean_abs_deviation_core: self-checking bench for the window MAD core
// Streams Q1.15 samples through the core under a range of window sizes. An
// in-bench model of the sample ring predicts each noise level. Both stream
// sides stall at random, and the window size is rewritten only between
// drained phases.
// ----------------------------------------------------------------------------
module tb_window_mean_abs_deviation_core;

  localparam int RING_DEPTH  = 64;
  localparam int N_ITEMS     = 1700;
  localparam int SETTLE_CYC  = 120;

  class wmad_scoreboard;
    logic signed [15:0]          ring [RING_DEPTH];
    bit [5:0]                    wr_pos;
    bit [6:0]                    fill;
    bit [wmad_pkg::CFG_W-1:0]    win_reg;
    logic [15:0]                 noise_q [$];
    int                          mismatches;
    int                          matched;

    function new();
      wr_pos     = '0;
      fill       = '0;
      win_reg    = wmad_pkg::CFG_RESET;
      mismatches = 0;
      matched    = 0;
    endfunction

    function void set_window(bit [wmad_pkg::CFG_W-1:0] v);
      win_reg = v;
    endfunction

    function int eff_k();
      if (win_reg == 0) return 1;
      if (win_reg > RING_DEPTH) return RING_DEPTH;
      return int'(win_reg);
    endfunction

    function int pending();
      return noise_q.size();
    endfunction

    function void note_sample(logic [15:0] s);
      int                 k;
      int                 oldest;
      int                 half;
      int                 sum;
      int                 d;
      logic signed [15:0] center;
      k = eff_k();
      ring[wr_pos] = s;
      wr_pos = wr_pos + 6'd1;
      if (fill < RING_DEPTH) fill = fill + 7'd1;
      if (int'(fill) < k) return;
      oldest = (int'(wr_pos) + RING_DEPTH - k) % RING_DEPTH;
      half   = k / 2;
      center = ring[(oldest + half) % RING_DEPTH];
      sum    = 0;
      for (int i = 0; i < k; i++) begin
        if (i == half) continue;
        d = int'(center) - int'(ring[(oldest + i) % RING_DEPTH]);
        sum += (d < 0) ? -d : d;
      end
      noise_q.push_back(16'(sum / k));
    endfunction

    function void check_result(logic [15:0] got);
      logic [15:0] exp_noise;
      if (noise_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: noise_level 0x%04h with none expected", $realtime, got);
        return;
      end
      exp_noise = noise_q.pop_front();
      if (got !== exp_noise) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: noise_level expected 0x%04h got 0x%04h", $realtime, exp_noise, got);
      end else begin
        matched++;
      end
    endfunction
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_wr_en;
  logic [wmad_pkg::CFG_W-1:0]   cfg_wr_data;
  logic                         in_tvalid;
  logic                         in_tready;
  logic [15:0]                  in_tdata;   // sample
  logic                         out_tvalid;
  logic                         out_tready;
  logic [15:0]                  out_tdata;  // noise_level

  wmad_scoreboard sb;
  int             items_sent;
  int             phases;
  int             min_k;
  int             max_k;
  bit             tx_calm;
  bit             rx_calm;
  int             stall_left;
  int             rx_gap;

  window_mean_abs_deviation_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #10_000_000;
    $display("tb_window_mean_abs_deviation_core failed");
    $finish;
  end

  // mostly short gaps, a few long ones
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 150);
  endfunction

  function logic [15:0] pick_sample(int mode, logic [15:0] base);
    case (mode)
      1: begin
        case ($urandom_range(0, 5))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h0000;
          3: return 16'hffff;
          4: return 16'h0001;
          default: return 16'h8001;
        endcase
      end
      2: return base + 16'($urandom_range(0, 63)) - 16'd32;
      3: return base;
      default: return 16'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        rx_gap = rx_calm ? 0 : pick_gap();
        if (rx_gap == 0) begin
          out_tready <= 1'b1;
        end else begin
          out_tready <= 1'b0;
          stall_left = rx_gap - 1;
        end
      end
    end
  end

  // leaves in_tvalid high after the transfer
  task send_sample(input logic [15:0] s);
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_sample(s);
    items_sent++;
  endtask

  task idle_tx(input int n);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 16'($urandom);
      repeat (n) @(posedge clk);
    end
  endtask

  task drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task write_window(input bit [wmad_pkg::CFG_W-1:0] v);
    drain_results();
    repeat (SETTLE_CYC) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    sb.set_window(v);
    cfg_wr_en   <= 1'b0;
    phases++;
    if (sb.eff_k() < min_k) min_k = sb.eff_k();
    if (sb.eff_k() > max_k) max_k = sb.eff_k();
  endtask

  function bit [wmad_pkg::CFG_W-1:0] pick_window();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return 7'd0;
    if (r < 16) return 7'd1;
    if (r < 22) return 7'd2;
    if (r < 60) return 7'($urandom_range(3, 8));
    if (r < 75) return 7'($urandom_range(9, 20));
    if (r < 83) return 7'($urandom_range(21, 40));
    if (r < 88) return 7'd64;
    if (r < 92) return 7'd127;
    if (r < 95) return 7'($urandom_range(65, 126));
    return 7'($urandom_range(41, 63));
  endfunction

  initial begin
    int          n_items;
    int          mode;
    logic [15:0] base;
    sb          = new();
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    items_sent  = 0;
    phases      = 0;
    min_k       = RING_DEPTH;
    max_k       = 1;
    tx_calm     = 1'b1;
    rx_calm     = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: partial fill, extremes, zero / one / two, oversized, shrink
    write_window(7'd3);
    send_sample(16'h7fff);
    send_sample(16'h8000);
    send_sample(16'h7fff);
    send_sample(16'h0000);
    send_sample(16'hffff);
    write_window(7'd0);
    send_sample(16'h8000);
    send_sample(16'h7fff);
    write_window(7'd1);
    send_sample(16'h0001);
    write_window(7'd2);
    send_sample(16'h8000);
    send_sample(16'h7fff);
    send_sample(16'h7fff);
    send_sample(16'h8000);
    write_window(7'd127);
    send_sample(16'h1234);
    send_sample(16'hedcb);
    send_sample(16'h8000);
    write_window(7'd5);
    send_sample(16'h7fff);
    send_sample(16'h0000);
    send_sample(16'h8000);
    write_window(7'd64);
    send_sample(16'h5555);
    send_sample(16'haaaa);

    while (items_sent < N_ITEMS) begin
      write_window(pick_window());
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      n_items = $urandom_range(10, 40) + ((sb.eff_k() > 20) ? sb.eff_k() / 2 : 0);
      mode    = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 3);
      base    = 16'($urandom);
      for (int i = 0; i < n_items; i++) begin
        send_sample(pick_sample(mode, base));
        if ($urandom_range(0, 99) == 0) drain_results();
        else idle_tx(tx_calm ? 0 : pick_gap());
      end
    end

    drain_results();
    repeat (SETTLE_CYC) @(posedge clk);
    if (sb.pending() != 0)
      $display("%0d expected noise levels never arrived", sb.pending());
    $display("Ran %0d samples over %0d window settings, K from %0d to %0d;",
             items_sent, phases, min_k, max_k);
    $display("%0d noise levels matched, %0d mismatches.", sb.matched, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_window_mean_abs_deviation_core passed");
    end else begin
      $display("tb_window_mean_abs_deviation_core failed");
    end
    $finish;
  end

endmodule

// ===== window_mean_abs_deviation_core.f =====
rtl/wmad_pkg.sv
rtl/wmad_ring_ram.sv
rtl/wmad_alu.sv
rtl/window_mean_abs_deviation_core.sv
tb/tb_window_mean_abs_deviation_core.sv
